// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, ignored while in reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked assertion, checked during reset too
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/sme_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sme_pkg;

  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int ACC_W         = 64;
  localparam int POS_W         = 3;
  localparam int CFG_DATA_W    = 4;

  typedef enum logic [1:0] {
    ACT_WRITE_A = 2'd0,
    ACT_WRITE_B = 2'd1,
    ACT_COMPUTE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic {
    CFG_MATRIX_SIZE = 1'b0,
    CFG_VECTOR_MODE = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_k;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] column;
  } sme_tag_t;

endpackage

`default_nettype wire

// ----- design/sme_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sme_ram
  import sme_pkg::*;
#(
  parameter int DEPTH  = MAX_DIM_DEF * MAX_DIM_DEF,
  parameter int ADDR_W = 6
) (
  input  wire logic              clk,
  input  wire logic              write,
  input  wire logic [ADDR_W-1:0] write_addr,
  input  wire logic [DATA_W-1:0] write_data,
  input  wire logic [ADDR_W-1:0] read_addr,
  output logic      [DATA_W-1:0] read_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (write) begin
      mem[write_addr] <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    read_data <= mem[read_addr];
  end

endmodule

`default_nettype wire

// ----- design/sme_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sme_seq
  import sme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF,
  parameter int IDX_W   = 3,
  parameter int ADDR_W  = 6
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              launch,
  input  wire logic [IDX_W-1:0]  size_m1,
  input  wire logic              vector_mode,
  input  wire logic              drain_done,
  output logic                   busy,
  output logic      [ADDR_W-1:0] a_addr,
  output logic      [ADDR_W-1:0] b_addr,
  output sme_tag_t               tag
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] nm1;
  logic [IDX_W-1:0] cm1;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;
  logic             k_end;
  logic             j_end;
  logic             i_end;

  assign k_end = (k == nm1);
  assign j_end = (j == cm1);
  assign i_end = (i == nm1);
  assign busy  = (state != ST_IDLE);

  assign a_addr = ADDR_W'(int'(i) * MAX_DIM + int'(k));
  assign b_addr = ADDR_W'(int'(k) * MAX_DIM + int'(j));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (launch) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (k_end && j_end && i_end) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tag.valid <= 1'b0;
    end else begin
      state     <= state_next;
      tag.valid <= (state == ST_RUN);
    end
    tag.first  <= (k == '0);
    tag.last_k <= k_end;
    tag.last   <= i_end && j_end;
    tag.row    <= POS_W'(i);
    tag.column <= POS_W'(j);
    if (state == ST_IDLE) begin
      nm1 <= size_m1;
      cm1 <= vector_mode ? '0 : size_m1;
      i   <= '0;
      j   <= '0;
      k   <= '0;
    end else if (state == ST_RUN) begin
      if (!k_end) begin
        k <= k + 1'b1;
      end else begin
        k <= '0;
        if (!j_end) begin
          j <= j + 1'b1;
        end else begin
          j <= '0;
          i <= i + 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/sme_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sme_mac
  import sme_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sme_tag_t          tag_in,
  input  wire logic [DATA_W-1:0] a_data,
  input  wire logic [DATA_W-1:0] b_data,
  output logic                   result_valid,
  output logic      [POS_W-1:0]  out_row,
  output logic      [POS_W-1:0]  out_column,
  output logic      [DATA_W-1:0] result_value,
  output logic                   last
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  sme_tag_t                  tag_p;
  sme_tag_t                  tag_s;
  logic signed [ACC_W-1:0]   full;
  logic signed [ACC_W-1:0]   prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W:0]     sum;
  logic signed [ACC_W-1:0]   acc_next;
  logic                      fits32;

  assign full = $signed(a_data) * $signed(b_data);
  assign sum  = {acc[ACC_W-1], acc} + {prod[ACC_W-1], prod};

  always_comb begin
    if (tag_p.first) begin
      acc_next = prod;
    end else if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_next = sum[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_next = sum[ACC_W-1:0];
    end
  end

  assign fits32 = (&acc[ACC_W-1:DATA_W-1]) || !(|acc[ACC_W-1:DATA_W-1]);

  // multiply, accumulate, saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_p.valid  <= 1'b0;
      tag_s.valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      tag_p.valid  <= tag_in.valid;
      tag_s.valid  <= tag_p.valid;
      result_valid <= tag_s.valid && tag_s.last_k;
    end
    prod         <= full >>> FRAC_BITS;
    tag_p.first  <= tag_in.first;
    tag_p.last_k <= tag_in.last_k;
    tag_p.last   <= tag_in.last;
    tag_p.row    <= tag_in.row;
    tag_p.column <= tag_in.column;
    if (tag_p.valid) begin
      acc <= acc_next;
    end
    tag_s.first  <= tag_p.first;
    tag_s.last_k <= tag_p.last_k;
    tag_s.last   <= tag_p.last;
    tag_s.row    <= tag_p.row;
    tag_s.column <= tag_p.column;
    out_row      <= tag_s.row;
    out_column   <= tag_s.column;
    last         <= tag_s.last;
    if (fits32) begin
      result_value <= acc[DATA_W-1:0];
    end else begin
      result_value <= acc[ACC_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

// ----- design/square_matrix_multiply_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Square matrix engine, signed Q16.16, C = A*B or c = A*b of size n.
// Command channel: a word is taken at a clock edge with start high and busy
// low. Action write A / write B store value at (row, column).
// In vector mode a B write stores vector element row. A compute word
// walks n*n (matrix) or n (vector) result elements, each a sum of n
// products, one multiply-accumulate per cycle through the A and B memories.
// Result channel: result_valid strobes for one cycle per element, row-major,
// with last on the final element. The receiver cannot stall it.
// A compute holds busy until its last result element has been output.
// Each memory has a single read port, and both feed one multiplier.
// Configuration: cfg_write with cfg_index selects matrix_size or
// vector_mode; write only while busy is low.
// Reset: matrix_size 8, vector mode off, engine idle. Store contents stay
// undefined until written.

module square_matrix_multiply_engine
  import sme_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            action,
  input  wire logic [POS_W-1:0]      row,
  input  wire logic [POS_W-1:0]      column,
  input  wire logic [DATA_W-1:0]     value,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       result_valid,
  output logic      [POS_W-1:0]      out_row,
  output logic      [POS_W-1:0]      out_column,
  output logic      [DATA_W-1:0]     result_value,
  output logic                       last
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic [CFG_DATA_W-1:0] matrix_size;
  logic                  vector_mode;
  logic                  accept;
  logic                  row_ok;
  logic                  col_ok;
  logic                  a_we;
  logic                  b_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     b_wr_addr;
  logic [ADDR_W-1:0]     a_rd_addr;
  logic [ADDR_W-1:0]     b_rd_addr;
  logic [DATA_W-1:0]     a_data;
  logic [DATA_W-1:0]     b_data;
  logic [IDX_W-1:0]      size_m1;
  logic                  launch;
  sme_tag_t              tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= CFG_DATA_W'(8);
      vector_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_MATRIX_SIZE: matrix_size <= cfg_data;
        CFG_VECTOR_MODE: vector_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (matrix_size == '0) begin
      size_m1 = '0;
    end else if (int'(matrix_size) > MAX_DIM) begin
      size_m1 = IDX_W'(MAX_DIM - 1);
    end else begin
      size_m1 = IDX_W'(int'(matrix_size) - 1);
    end
  end

  assign accept    = start && !busy;
  assign row_ok    = (int'(row) < MAX_DIM);
  assign col_ok    = (int'(column) < MAX_DIM);
  assign wr_addr   = ADDR_W'(int'(row) * MAX_DIM + int'(column));
  assign b_wr_addr = vector_mode ? ADDR_W'(int'(row) * MAX_DIM) : wr_addr;
  assign a_we      = accept && (action == ACT_WRITE_A) && row_ok && col_ok;
  assign b_we      = accept && (action == ACT_WRITE_B) && row_ok && (vector_mode || col_ok);
  assign launch    = accept && (action == ACT_COMPUTE);

  sme_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_a_ram (
    .clk        (clk),
    .write      (a_we),
    .write_addr (wr_addr),
    .write_data (value),
    .read_addr  (a_rd_addr),
    .read_data  (a_data)
  );

  sme_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_b_ram (
    .clk        (clk),
    .write      (b_we),
    .write_addr (b_wr_addr),
    .write_data (value),
    .read_addr  (b_rd_addr),
    .read_data  (b_data)
  );

  sme_seq #(
    .MAX_DIM (MAX_DIM),
    .IDX_W   (IDX_W),
    .ADDR_W  (ADDR_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .launch      (launch),
    .size_m1     (size_m1),
    .vector_mode (vector_mode),
    .drain_done  (result_valid && last),
    .busy        (busy),
    .a_addr      (a_rd_addr),
    .b_addr      (b_rd_addr),
    .tag         (tag)
  );

  sme_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk          (clk),
    .rst          (rst),
    .tag_in       (tag),
    .a_data       (a_data),
    .b_data       (b_data),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_column   (out_column),
    .result_value (result_value),
    .last         (last)
  );

`include "assert_macros.svh"

  `ASSERT_CLK(a_compute_busy, launch |=> busy, "compute word did not raise busy")
  `ASSERT_CLK(a_last_idle, result_valid && last |=> !busy, "busy held after last word")
  `ASSERT_CLK(a_idle_quiet, !busy |-> !result_valid, "result word while idle")
  `ASSERT_CLK(a_no_write_busy, busy |-> !(a_we || b_we), "store write while computing")

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import sme_pkg::*;

  localparam int DIM         = MAX_DIM_DEF;
  localparam int FRAC        = FRAC_BITS_DEF;
  localparam int WORD_TARGET = 460;
  localparam int QUIET_LIMIT = 2000;
  localparam int CFG_HOLD    = 4;
  localparam int DRAIN       = 40;

  typedef enum logic {ROW_WORD, ROW_MODE} row_kind_t;

  // mode rows: v[3:0] matrix size, v[4] vector mode
  typedef struct packed {
    row_kind_t        kind;
    action_t          act;
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
    logic [31:0]      v;
    logic             typed;
    logic [31:0]      ev;
  } stim_row_t;

  typedef struct packed {
    logic [POS_W-1:0] r;
    logic [POS_W-1:0] c;
    logic [31:0]      v;
    logic             l;
  } elem_t;

  localparam int N_DIRECTED = 30;

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{ROW_MODE, ACT_NONE,    3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_A, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd0, 3'd0, 32'h7fff_ffff, 1'b0, 32'h0},
    '{ROW_WORD, ACT_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h7fff_ffff},
    '{ROW_WORD, ACT_WRITE_A, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_COMPUTE, 3'd7, 3'd7, 32'hffff_ffff, 1'b1, 32'h8000_0000},
    '{ROW_WORD, ACT_WRITE_B, 3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'h7fff_ffff},
    '{ROW_WORD, ACT_WRITE_A, 3'd0, 3'd0, 32'hffff_ffff, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd0, 3'd0, 32'h0000_0001, 1'b0, 32'h0},
    '{ROW_WORD, ACT_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'hffff_ffff},
    '{ROW_WORD, ACT_NONE,    3'd7, 3'd7, 32'hffff_ffff, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_A, 3'd0, 3'd0, 32'h0001_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd0, 3'd0, 32'hfffe_0000, 1'b0, 32'h0},
    '{ROW_MODE, ACT_NONE,    3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b1, 32'hfffe_0000},
    '{ROW_MODE, ACT_NONE,    3'd0, 3'd0, 32'h0000_0012, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_A, 3'd0, 3'd1, 32'h0002_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_A, 3'd1, 3'd0, 32'hfff8_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_A, 3'd1, 3'd1, 32'h0000_8000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd1, 3'd5, 32'h0003_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_A, 3'd7, 3'd7, 32'h7fff_ffff, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd7, 3'd2, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_MODE, ACT_NONE,    3'd0, 3'd0, 32'h0000_0002, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd7, 3'd7, 32'h8000_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd0, 3'd1, 32'h0000_4000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd1, 3'd0, 32'hffff_c000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_WRITE_B, 3'd1, 3'd1, 32'h0010_0000, 1'b0, 32'h0},
    '{ROW_WORD, ACT_COMPUTE, 3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [1:0]            action = ACT_NONE;
  logic [POS_W-1:0]      row = '0;
  logic [POS_W-1:0]      column = '0;
  logic [DATA_W-1:0]     value = '0;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = CFG_MATRIX_SIZE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  result_valid;
  logic [POS_W-1:0]      out_row;
  logic [POS_W-1:0]      out_column;
  logic [DATA_W-1:0]     result_value;
  logic                  last;

  logic [31:0] a_mem [DIM*DIM];
  logic [31:0] b_mem [DIM*DIM];
  bit          a_set [DIM*DIM];
  bit          b_set [DIM*DIM];
  logic [3:0]  mode_size = 4'd8;
  logic        mode_vector = 1'b0;

  elem_t pending_elems [$];
  bit    idling = 1'b1;
  int    words_sent = 0;
  int    computes_sent = 0;
  int    mode_changes = 0;
  int    elems_checked = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;

  square_matrix_multiply_engine u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .row          (row),
    .column       (column),
    .value        (value),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .out_row      (out_row),
    .out_column   (out_column),
    .result_value (result_value),
    .last         (last)
  );

  always #6 clk = ~clk;

  function automatic int dim_in_use();
    if (mode_size == 4'd0) return 1;
    if (mode_size > DIM) return DIM;
    return int'(mode_size);
  endfunction

  function automatic void predict_product();
    int n;
    int cols;
    logic signed [63:0] acc;
    logic signed [63:0] pa;
    logic signed [63:0] pb;
    logic signed [63:0] prod;
    logic signed [64:0] sum;
    logic [31:0] sat;
    n = dim_in_use();
    cols = mode_vector ? 1 : n;
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < cols; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          pa = $signed(a_mem[i*DIM+k]);
          pb = $signed(b_mem[k*DIM+j]);
          prod = (pa * pb) >>> FRAC;
          sum = {acc[63], acc} + {prod[63], prod};
          if (sum[64] != sum[63])
            acc = sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
          else
            acc = sum[63:0];
        end
        if (acc > 64'sd2147483647)
          sat = 32'h7fff_ffff;
        else if (acc < -64'sd2147483648)
          sat = 32'h8000_0000;
        else
          sat = acc[31:0];
        pending_elems.push_back('{i[2:0], j[2:0], sat, (i == n - 1) && (j == cols - 1)});
      end
    end
  endfunction

  function automatic void flag(string what);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: mismatch: %s", what);
  endfunction

  function automatic logic [31:0] pick_value();
    int sel;
    logic [31:0] offs;
    sel = $urandom_range(0, 99);
    if (sel < 25)
      return $urandom;
    if (sel < 40) begin
      case ($urandom_range(0, 4))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hffff_ffff;
        default: return 32'h0001_0000;
      endcase
    end
    offs = $urandom_range(0, 32'h000f_ffff);
    return offs - 32'h0008_0000;
  endfunction

  task automatic send_word(action_t act, logic [2:0] r, logic [2:0] c, logic [31:0] v,
                           logic typed, logic [31:0] ev);
    while (idling && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start  <= 1'b1;
    action <= act;
    row    <= r;
    column <= c;
    value  <= v;
    do @(posedge clk); while (busy);
    case (act)
      ACT_WRITE_A: begin
        a_mem[r*DIM+c] = v;
        a_set[r*DIM+c] = 1'b1;
      end
      ACT_WRITE_B: begin
        if (mode_vector) begin
          b_mem[r*DIM] = v;
          b_set[r*DIM] = 1'b1;
        end else begin
          b_mem[r*DIM+c] = v;
          b_set[r*DIM+c] = 1'b1;
        end
      end
      ACT_COMPUTE: begin
        computes_sent++;
        if (typed)
          pending_elems.push_back('{3'd0, 3'd0, ev, 1'b1});
        else
          predict_product();
      end
      default: ;
    endcase
    if (act != ACT_NONE)
      words_sent++;
  endtask

  task automatic set_mode(logic [3:0] sz, logic vm);
    start <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (CFG_HOLD) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_MATRIX_SIZE;
    cfg_data  <= sz;
    @(posedge clk);
    cfg_index <= CFG_VECTOR_MODE;
    cfg_data  <= {3'b000, vm};
    @(posedge clk);
    cfg_write   <= 1'b0;
    mode_size   = sz;
    mode_vector = vm;
    mode_changes++;
  endtask

  always @(posedge clk) begin : check_elems
    elem_t want;
    if (!rst && result_valid) begin
      elems_checked++;
      if (pending_elems.size() == 0) begin
        flag($sformatf("unexpected word (%0d,%0d) %h last %b",
                       out_row, out_column, result_value, last));
      end else begin
        want = pending_elems.pop_front();
        if (out_row !== want.r || out_column !== want.c || result_value !== want.v ||
            last !== want.l)
          flag($sformatf("want (%0d,%0d) %h last %b, got (%0d,%0d) %h last %b",
                         want.r, want.c, want.v, want.l,
                         out_row, out_column, result_value, last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: no progress for %0d cycles", QUIET_LIMIT);
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int sel;
    logic [3:0] sz;
    logic [2:0] r;
    logic [2:0] c;
    stim_row_t sr;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int idx = 0; idx < N_DIRECTED; idx++) begin
      sr = directed_rows[idx];
      if (sr.kind == ROW_MODE)
        set_mode(sr.v[3:0], sr.v[4]);
      else
        send_word(sr.act, sr.r, sr.c, sr.v, sr.typed, sr.ev);
    end

    while (words_sent < WORD_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 45)
        sz = 4'($urandom_range(1, 3));
      else if (sel < 65)
        sz = 4'($urandom_range(4, 7));
      else if (sel < 82)
        sz = 4'd8;
      else begin
        sz = 4'($urandom_range(8, 15));
        if (sz == 4'd8)
          sz = 4'd0;
      end
      set_mode(sz, 1'($urandom_range(0, 1)));
      n = dim_in_use();
      repeat ($urandom_range(1, 3)) begin
        idling = !(words_sent >= 160 && words_sent < 280);
        for (int i = 0; i < n; i++)
          for (int k = 0; k < n; k++)
            if (!a_set[i*DIM+k])
              send_word(ACT_WRITE_A, 3'(i), 3'(k), pick_value(), 1'b0, '0);
        for (int k = 0; k < n; k++) begin
          if (mode_vector) begin
            if (!b_set[k*DIM])
              send_word(ACT_WRITE_B, 3'(k), 3'($urandom_range(0, 7)), pick_value(),
                        1'b0, '0);
          end else begin
            for (int j = 0; j < n; j++)
              if (!b_set[k*DIM+j])
                send_word(ACT_WRITE_B, 3'(k), 3'(j), pick_value(), 1'b0, '0);
          end
        end
        repeat ($urandom_range(0, 8)) begin
          r = 3'(($urandom_range(0, 99) < 80) ? $urandom_range(0, n - 1)
                                              : $urandom_range(0, 7));
          c = 3'(($urandom_range(0, 99) < 80) ? $urandom_range(0, n - 1)
                                              : $urandom_range(0, 7));
          sel = $urandom_range(0, 99);
          if (sel < 10)
            send_word(ACT_NONE, r, c, $urandom, 1'b0, '0);
          else if (sel < 55)
            send_word(ACT_WRITE_A, r, c, pick_value(), 1'b0, '0);
          else
            send_word(ACT_WRITE_B, r, c, pick_value(), 1'b0, '0);
        end
        send_word(ACT_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), $urandom,
                  1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("tb: %0d words accepted, %0d of them computes, over %0d mode settings",
             words_sent, computes_sent, mode_changes);
    $display("tb: %0d result words checked, %0d mismatches", elems_checked, mismatches);
    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/sme_pkg.sv
design/sme_ram.sv
design/sme_seq.sv
design/sme_mac.sv
design/square_matrix_multiply_engine.sv
sim/tb.sv
